// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the limiter checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every clock edge outside reset
`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// check prop at every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

// ----- rtl/dtbl_pkg.sv -----
// ----------------------------------------------------------------------------
// dtbl_pkg
// Field widths, register map, reset values and config types of the limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package dtbl_pkg;

    localparam int unsigned TS_W    = 48;
    localparam int unsigned SIZE_W  = 16;
    localparam int unsigned RATE_W  = 32;
    localparam int unsigned BURST_W = 16;
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    typedef logic t_reg_idx;
    localparam t_reg_idx REG_RATE  = 1'b0;
    localparam t_reg_idx REG_BURST = 1'b1;

    localparam logic [RATE_W-1:0]  RATE_RST  = 32'd1311;
    localparam logic [BURST_W-1:0] BURST_RST = 16'd8;

    typedef struct packed {
        logic [RATE_W-1:0]  refill_rate;
        logic [BURST_W-1:0] burst_tokens;
    } t_cfg;

endpackage

`default_nettype wire

// ----- rtl/dtbl_if.sv -----
// ----------------------------------------------------------------------------
// dtbl_req_if / dtbl_rsp_if
// Valid/ready channels for request beats and grant beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtbl_req_if import dtbl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TS_W-1:0]   timestamp;
    logic [SIZE_W-1:0] request_size;

    modport source (output valid, output timestamp, output request_size, input ready);
    modport sink   (input valid, input timestamp, input request_size, output ready);
endinterface

interface dtbl_rsp_if;
    logic valid;
    logic ready;
    logic granted;

    modport source (output valid, output granted, input ready);
    modport sink   (input valid, input granted, output ready);
endinterface

`default_nettype wire

// ----- rtl/dtbl_regs.sv -----
// ----------------------------------------------------------------------------
// dtbl_regs
// APB register file holding refill rate and burst size.
// ----------------------------------------------------------------------------
`default_nettype none

module dtbl_regs import dtbl_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr;

    assign idx    = paddr[2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.refill_rate  <= RATE_RST;
            r_cfg.burst_tokens <= BURST_RST;
        end else if (wr) begin
            case (idx)
                REG_RATE:  r_cfg.refill_rate  <= pwdata;
                REG_BURST: r_cfg.burst_tokens <= pwdata[BURST_W-1:0];
                default:   r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_RATE:  prdata = r_cfg.refill_rate;
            REG_BURST: prdata = {{(PDATA_W-BURST_W){1'b0}}, r_cfg.burst_tokens};
            default:   prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/dtbl_core.sv -----
// ----------------------------------------------------------------------------
// dtbl_core
// Request register, single-pass bucket refill and debit, grant register.
// ----------------------------------------------------------------------------
`default_nettype none

module dtbl_core import dtbl_pkg::*; #(
    parameter int unsigned CMD_BYTES     = 1024,
    parameter int unsigned MAX_GAP_TICKS = 10000,
    parameter int unsigned FRAC_BITS     = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    dtbl_req_if.sink  i_req,
    dtbl_rsp_if.source o_rsp
);

    localparam int unsigned CBW = $clog2(CMD_BYTES + 1);
    localparam int unsigned DTW = $clog2(MAX_GAP_TICKS + 1);
    localparam int unsigned TW  = BURST_W + FRAC_BITS;
    localparam int unsigned BW  = BURST_W + CBW + FRAC_BITS;
    localparam int unsigned PW  = (DTW + RATE_W > TW) ? DTW + RATE_W : TW;

    localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(CMD_BYTES);
    localparam logic [TS_W-1:0]   GAP_MAX  = TS_W'(MAX_GAP_TICKS);
    localparam logic [TW-1:0]     TOK_ONE  = TW'(1) << FRAC_BITS;

    logic              r_in_v;
    logic [TS_W-1:0]   r_ts;
    logic [SIZE_W-1:0] r_size;

    logic              r_started;
    logic [TS_W-1:0]   r_last;
    logic [TW-1:0]     r_tok;
    logic [BW-1:0]     r_byte;

    logic              r_out_v;
    logic              r_granted;

    logic              out_free;
    logic              fire;
    logic              oversize;
    logic [TW-1:0]     tok_cap;
    logic [BW-1:0]     byte_cap;
    logic [TS_W-1:0]   eff_last;
    logic              ahead;
    logic [TS_W-1:0]   diff;
    logic [DTW-1:0]    dt;
    logic [PW-1:0]     prod;
    logic [TW-1:0]     gain;
    logic [TW-1:0]     eff_tok;
    logic [BW-1:0]     eff_byte;
    logic [TW:0]       tsum;
    logic [BW-1:0]     bgain;
    logic [BW:0]       bsum;
    logic [TW-1:0]     tok_new;
    logic [BW-1:0]     byte_new;
    logic [BW-1:0]     need;
    logic              grant;

    assign out_free    = !r_out_v || o_rsp.ready;
    assign fire        = r_in_v && out_free;
    assign i_req.ready = !r_in_v || out_free;
    assign o_rsp.valid   = r_out_v;
    assign o_rsp.granted = r_granted;

    always_comb begin
        oversize = r_size > SIZE_MAX;
        tok_cap  = TW'(i_cfg.burst_tokens) << FRAC_BITS;
        byte_cap = (BW'(i_cfg.burst_tokens) * BW'(CMD_BYTES)) << FRAC_BITS;

        eff_last = r_started ? r_last : r_ts;
        eff_tok  = r_started ? r_tok  : tok_cap;
        eff_byte = r_started ? r_byte : byte_cap;

        ahead = r_ts > eff_last;
        diff  = r_ts - eff_last;
        if (!ahead) begin
            dt = '0;
        end else if (diff > GAP_MAX) begin
            dt = DTW'(MAX_GAP_TICKS);
        end else begin
            dt = diff[DTW-1:0];
        end

        prod = PW'(dt) * PW'(i_cfg.refill_rate);
        gain = (prod > PW'(tok_cap)) ? tok_cap : prod[TW-1:0];

        tsum    = {1'b0, eff_tok} + {1'b0, gain};
        tok_new = (tsum > {1'b0, tok_cap}) ? tok_cap : tsum[TW-1:0];

        bgain    = BW'(gain) * BW'(CMD_BYTES);
        bsum     = {1'b0, eff_byte} + {1'b0, bgain};
        byte_new = (bsum > {1'b0, byte_cap}) ? byte_cap : bsum[BW-1:0];

        need  = BW'(r_size) << FRAC_BITS;
        grant = !oversize && (tok_new >= TOK_ONE) && (byte_new >= need);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v    <= 1'b0;
            r_out_v   <= 1'b0;
            r_started <= 1'b0;
            r_last    <= '0;
            r_tok     <= '0;
            r_byte    <= '0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                r_in_v <= 1'b1;
                r_ts   <= i_req.timestamp;
                r_size <= i_req.request_size;
            end else if (fire) begin
                r_in_v <= 1'b0;
            end

            if (fire) begin
                r_out_v   <= 1'b1;
                r_granted <= grant;
                if (!oversize) begin
                    r_started <= 1'b1;
                    r_last    <= ahead ? r_ts : eff_last;
                    r_tok     <= grant ? tok_new - TOK_ONE : tok_new;
                    r_byte    <= grant ? byte_new - need : byte_new;
                end
            end else if (o_rsp.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/dual_token_bucket_limiter.sv -----
// A request beat is registered, then its grant beat is registered once the output is free.
// Throughput: one request per cycle unless o_rsp.ready stalls; set by the single-pass
//   refill/debit path (one 14x32 multiply, adds and compares) closing on the bucket registers.
// Reset: synchronous, active low; clears both channel stages, the started flag and
//   the bucket state, and loads refill_rate = 1311 and burst_tokens = 8.
// ----------------------------------------------------------------------------
// dual_token_bucket_limiter
// Request and byte token buckets with APB configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_token_bucket_limiter import dtbl_pkg::*; #(
    parameter int unsigned CMD_BYTES     = 1024,
    parameter int unsigned MAX_GAP_TICKS = 10000,
    parameter int unsigned FRAC_BITS     = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    dtbl_req_if.sink                i_req,
    dtbl_rsp_if.source              o_rsp,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    t_cfg cfg;

    dtbl_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dtbl_core #(
        .CMD_BYTES     (CMD_BYTES),
        .MAX_GAP_TICKS (MAX_GAP_TICKS),
        .FRAC_BITS     (FRAC_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire

// ----- rtl/dtbl_checker.sv -----
// ----------------------------------------------------------------------------
// dtbl_checker
// Port-level checks of the limiter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
`default_nettype none

module dtbl_checker import dtbl_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire logic               i_granted,
    input wire logic               psel,
    input wire logic               penable,
    input wire logic               pwrite,
    input wire logic [PADDR_W-1:0] paddr,
    input wire logic [PDATA_W-1:0] pwdata,
    input wire logic [PDATA_W-1:0] prdata
);

    `ASSERT_RST(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)
    `ASSERT_RST(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(i_granted))
    `ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid)
    `ASSERT_RST(a_rate_readback, i_clk, i_rst_n, (psel && penable && pwrite && paddr[2] == REG_RATE) ##1 (psel && !pwrite && paddr[2] == REG_RATE) |-> prdata == $past(pwdata))

endmodule

bind dual_token_bucket_limiter dtbl_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_granted   (o_rsp.granted),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata)
);

`default_nettype wire
